// ----- src/rmq_pkg.sv -----
package rmq_pkg;

    // width of every matrix entry and every quaternion component
    localparam int DATA_W = 16;

    // default number of fraction bits (Q1.14)
    localparam int FRAC_BITS_DEF = 14;

    // number of quaternion components
    localparam int NUM_COMP = 4;

endpackage

// ----- src/rmq_isqrt.sv -----
// pipelined integer square root, one root bit per stage, several lanes in step
module rmq_isqrt #(
    parameter int IW    = 32,
    parameter int LANES = 1,
    parameter int SDW   = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IW-1:0]       v [LANES],
    input  logic [SDW-1:0]      side,
    output logic                out_valid,
    output logic [IW/2-1:0]     root [LANES],
    output logic [SDW-1:0]      out_side
);

    localparam int RW = IW / 2;

    logic [IW-1:0]   v_p    [RW+1][LANES];
    logic [RW+1:0]   rem_p  [RW+1][LANES];
    logic [RW-1:0]   root_p [RW+1][LANES];
    logic [SDW-1:0]  side_p [RW+1];
    logic [RW:0]     valid_p;

    // stage zero is the request itself
    assign valid_p[0] = in_valid;
    assign side_p[0]  = side;

    genvar k, l;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_in
            assign v_p[0][l]    = v[l];
            assign rem_p[0][l]  = '0;
            assign root_p[0][l] = '0;
        end

        for (k = 0; k < RW; k++)
        begin : g_stage
            // valid bit of this stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_p[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_p[k+1] <= valid_p[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_p[k+1] <= side_p[k];
                end
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [RW+1:0] rem_sh;
                logic [RW+1:0] trial;
                logic          ge;

                // bring down the next two radicand bits and try a one digit
                assign rem_sh = {rem_p[k][l][RW-1:0], v_p[k][l][IW-1-2*k -: 2]};
                assign trial  = {root_p[k][l], 2'b01};
                assign ge     = (rem_sh >= trial);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        v_p[k+1][l]    <= v_p[k][l];
                        rem_p[k+1][l]  <= ge ? (rem_sh - trial) : rem_sh;
                        root_p[k+1][l] <= {root_p[k][l][RW-2:0], ge};
                    end
                end
            end
        end

        for (l = 0; l < LANES; l++)
        begin : g_out
            assign root[l] = root_p[RW][l];
        end
    endgenerate

    assign out_valid = valid_p[RW];
    assign out_side  = side_p[RW];

endmodule

// ----- src/rmq_div.sv -----
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module rmq_div #(
    parameter int DW    = 31,
    parameter int NW    = 17,
    parameter int QW    = 15,
    parameter int LANES = 4,
    parameter int SDW   = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DW-1:0]       num [LANES],
    input  logic [NW-1:0]       den,
    input  logic [SDW-1:0]      side,
    output logic                out_valid,
    output logic [QW-1:0]       quo [LANES],
    output logic [SDW-1:0]      out_side
);

    logic [DW-1:0]   num_p [QW+1][LANES];
    logic [NW-1:0]   rem_p [QW+1][LANES];
    logic [QW-1:0]   quo_p [QW+1][LANES];
    logic [NW-1:0]   den_p [QW+1];
    logic [SDW-1:0]  side_p [QW+1];
    logic [QW:0]     valid_p;

    assign valid_p[0] = in_valid;
    assign side_p[0]  = side;
    assign den_p[0]   = den;

    genvar k, l;
    generate
        // the upper numerator bits are known to be below the divisor
        for (l = 0; l < LANES; l++)
        begin : g_in
            assign num_p[0][l] = num[l];
            assign rem_p[0][l] = NW'(num[l][DW-1:QW]);
            assign quo_p[0][l] = '0;
        end

        for (k = 0; k < QW; k++)
        begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_p[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_p[k+1] <= valid_p[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_p[k+1] <= side_p[k];
                    den_p[k+1]  <= den_p[k];
                end
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [NW:0] rem_sh;
                logic [NW:0] rem_sub;
                logic        ge;

                // shift in one numerator bit and subtract when it fits
                assign rem_sh  = {rem_p[k][l], num_p[k][l][QW-1-k]};
                assign ge      = (rem_sh >= {1'b0, den_p[k]});
                assign rem_sub = ge ? (rem_sh - {1'b0, den_p[k]}) : rem_sh;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        num_p[k+1][l] <= num_p[k][l];
                        rem_p[k+1][l] <= rem_sub[NW-1:0];
                        quo_p[k+1][l] <= {quo_p[k][l][QW-2:0], ge};
                    end
                end
            end
        end

        for (l = 0; l < LANES; l++)
        begin : g_out
            assign quo[l] = quo_p[QW][l];
        end
    endgenerate

    assign out_valid = valid_p[QW];
    assign out_side  = side_p[QW];

endmodule

// ----- src/rotation_matrix_to_quaternion_unit.sv -----
// Converts one 3x3 rotation matrix (signed fixed point, FRAC_BITS fraction bits)
// into a unit quaternion w, x, y, z per request, saturated to plus or minus 1.0.
// A new matrix is taken every cycle; the pipeline only holds when the output
// request is stalled. A request passes through the trace-sum register, the
// digit-recurrence square-root pipeline for the candidate magnitudes, the
// square and sum registers, a second square-root pipeline for the length,
// the rounded-numerator register, the bit-per-stage divider that normalizes
// each component, and the output register (default format Q1.14).
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0] r11,
    input  logic signed [rmq_pkg::DATA_W-1:0] r12,
    input  logic signed [rmq_pkg::DATA_W-1:0] r13,
    input  logic signed [rmq_pkg::DATA_W-1:0] r21,
    input  logic signed [rmq_pkg::DATA_W-1:0] r22,
    input  logic signed [rmq_pkg::DATA_W-1:0] r23,
    input  logic signed [rmq_pkg::DATA_W-1:0] r31,
    input  logic signed [rmq_pkg::DATA_W-1:0] r32,
    input  logic signed [rmq_pkg::DATA_W-1:0] r33,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rmq_pkg::DATA_W-1:0] quat_w,
    output logic signed [rmq_pkg::DATA_W-1:0] quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0] quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0] quat_z
);

    localparam int DW   = rmq_pkg::DATA_W;
    localparam int NC   = rmq_pkg::NUM_COMP;
    localparam int SW   = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 3;
    localparam int IW1  = ((SW - 1 + FRAC_BITS + 1) / 2) * 2;
    localparam int AW   = IW1 / 2;
    localparam int IW2  = 2 * AW + 2;
    localparam int NW   = IW2 / 2;
    localparam int NUMW = AW + FRAC_BITS + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int OW   = FRAC_BITS + 2;

    localparam logic signed [SW-1:0] ONE_S = SW'(longint'(1) << FRAC_BITS);
    localparam logic [QW-1:0]        ONE_Q = QW'(longint'(1) << FRAC_BITS);

    logic en;

    // whole pipeline advances unless the output register is held
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // ---------------- stage A: trace sums, pick largest, signs ----------------
    logic signed [SW-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
    logic signed [SW-1:0] s_raw [NC];
    logic [SW-2:0]        s_cl  [NC];
    logic [1:0]           big;
    logic                 p32m23, p13m31, p21m12, p21p12, p13p31, p32p23;
    logic [NC-1:0]        sg_next;

    assign e11 = SW'(r11);
    assign e12 = SW'(r12);
    assign e13 = SW'(r13);
    assign e21 = SW'(r21);
    assign e22 = SW'(r22);
    assign e23 = SW'(r23);
    assign e31 = SW'(r31);
    assign e32 = SW'(r32);
    assign e33 = SW'(r33);

    assign s_raw[0] =  e11 + e22 + e33 + ONE_S;
    assign s_raw[1] =  e11 - e22 - e33 + ONE_S;
    assign s_raw[2] = -e11 + e22 - e33 + ONE_S;
    assign s_raw[3] = -e11 - e22 + e33 + ONE_S;

    // negative sums clamp to zero
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            s_cl[i] = s_raw[i][SW-1] ? '0 : s_raw[i][SW-2:0];
        end
    end

    // largest clamped sum, ties to the lower index
    always_comb
    begin
        logic [SW-2:0] best;
        best = s_cl[0];
        big  = 2'd0;
        for (int i = 1; i < NC; i++)
        begin
            if (s_cl[i] > best)
            begin
                best = s_cl[i];
                big  = 2'(i);
            end
        end
    end

    // sign bits: one means non-negative
    assign p32m23 = !(e32 - e23 < 0);
    assign p13m31 = !(e13 - e31 < 0);
    assign p21m12 = !(e21 - e12 < 0);
    assign p21p12 = !(e21 + e12 < 0);
    assign p13p31 = !(e13 + e31 < 0);
    assign p32p23 = !(e32 + e23 < 0);

    always_comb
    begin
        case (big)
            2'd0:    sg_next = {p21m12, p13m31, p32m23, 1'b1};
            2'd1:    sg_next = {p13p31, p21p12, 1'b1, p32m23};
            2'd2:    sg_next = {p32p23, 1'b1, p21p12, p13m31};
            default: sg_next = {1'b1, p32p23, p13p31, p21m12};
        endcase
    end

    logic          a_valid_reg;
    logic [SW-2:0] s_reg [NC];
    logic [NC-1:0] sg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= s_cl;
            sg_reg <= sg_next;
        end
    end

    // ---------------- candidate magnitudes ----------------
    logic [IW1-1:0] rad1 [NC];
    logic [AW-1:0]  amag [NC];
    logic           m_valid;
    logic [NC-1:0]  m_sg;

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            rad1[i] = IW1'({s_reg[i], {FRAC_BITS{1'b0}}});
        end
    end

    rmq_isqrt #(
        .IW    (IW1),
        .LANES (NC),
        .SDW   (NC)
    ) u_sqrt_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .v         (rad1),
        .side      (sg_reg),
        .out_valid (m_valid),
        .root      (amag),
        .out_side  (m_sg)
    );

    // ---------------- squares, then their sum ----------------
    logic            sq_valid_reg;
    logic [2*AW-1:0] sq_reg  [NC];
    logic [AW-1:0]   sq_a_reg [NC];
    logic [NC-1:0]   sq_sg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NC; i++)
            begin
                sq_reg[i] <= amag[i] * amag[i];
            end
            sq_a_reg  <= amag;
            sq_sg_reg <= m_sg;
        end
    end

    logic           ss_valid_reg;
    logic [IW2-1:0] ss_reg;
    logic [AW-1:0]  ss_a_reg [NC];
    logic [NC-1:0]  ss_sg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ss_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= IW2'(sq_reg[0]) + IW2'(sq_reg[1]) + IW2'(sq_reg[2])
                    + IW2'(sq_reg[3]);
            ss_a_reg  <= sq_a_reg;
            ss_sg_reg <= sq_sg_reg;
        end
    end

    // ---------------- length ----------------
    localparam int SIDE2 = NC * AW + NC;

    logic [IW2-1:0]   rad2 [1];
    logic [NW-1:0]    nlen [1];
    logic [SIDE2-1:0] side2_in, side2_out;
    logic             n_valid;

    assign rad2[0]  = ss_reg;
    assign side2_in = {ss_a_reg[3], ss_a_reg[2], ss_a_reg[1], ss_a_reg[0], ss_sg_reg};

    rmq_isqrt #(
        .IW    (IW2),
        .LANES (1),
        .SDW   (SIDE2)
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ss_valid_reg),
        .v         (rad2),
        .side      (side2_in),
        .out_valid (n_valid),
        .root      (nlen),
        .out_side  (side2_out)
    );

    // ---------------- rounded numerators ----------------
    logic            nm_valid_reg;
    logic [NUMW-1:0] nm_reg [NC];
    logic [NW-1:0]   nm_den_reg;
    logic [NC-1:0]   nm_sg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_valid_reg <= n_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NC; i++)
            begin
                nm_reg[i] <= NUMW'({side2_out[NC + i*AW +: AW], {FRAC_BITS{1'b0}}})
                           + NUMW'(nlen[0] >> 1);
            end
            nm_den_reg <= nlen[0];
            nm_sg_reg  <= side2_out[NC-1:0];
        end
    end

    // ---------------- normalize ----------------
    logic [QW-1:0] quo [NC];
    logic [NC:0]   dv_side_in, dv_side_out;
    logic          d_valid;

    assign dv_side_in = {(nm_den_reg == '0), nm_sg_reg};

    rmq_div #(
        .DW    (NUMW),
        .NW    (NW),
        .QW    (QW),
        .LANES (NC),
        .SDW   (NC + 1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid_reg),
        .num       (nm_reg),
        .den       (nm_den_reg),
        .side      (dv_side_in),
        .out_valid (d_valid),
        .quo       (quo),
        .out_side  (dv_side_out)
    );

    // ---------------- saturate, sign, output register ----------------
    logic [DW-1:0] q_next [NC];
    logic [DW-1:0] q_reg  [NC];
    logic          o_valid_reg;

    always_comb
    begin
        logic [QW-1:0] mag;
        logic [OW-1:0] sv;
        for (int i = 0; i < NC; i++)
        begin
            mag = (quo[i] > ONE_Q) ? ONE_Q : quo[i];
            if (dv_side_out[NC])
            begin
                // zero length gives the identity
                sv = (i == 0) ? OW'(ONE_Q) : '0;
            end
            else
            begin
                sv = dv_side_out[i] ? OW'(mag) : (OW'(0) - OW'(mag));
            end
            q_next[i] = DW'(signed'(sv));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign quat_w    = q_reg[0];
    assign quat_x    = q_reg[1];
    assign quat_y    = q_reg[2];
    assign quat_z    = q_reg[3];

endmodule

// ----- src/rmq_checker.sv -----
module rmq_checker #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [rmq_pkg::DATA_W-1:0] quat_w,
    input logic signed [rmq_pkg::DATA_W-1:0] quat_x,
    input logic signed [rmq_pkg::DATA_W-1:0] quat_y,
    input logic signed [rmq_pkg::DATA_W-1:0] quat_z
);

    localparam logic signed [rmq_pkg::DATA_W-1:0] ONE_V =
        rmq_pkg::DATA_W'(longint'(1) << FRAC_BITS);

    // the block only holds off requests when its output is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output request dropped while stalled");

    // scalar part stays within plus or minus one (checked while FRAC_BITS is below DATA_W - 1, as at Q1.14)
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (FRAC_BITS < rmq_pkg::DATA_W - 1)) |->
        (quat_w <= ONE_V && quat_w >= -ONE_V))
        else $error("quat_w out of range");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // handshakes and offered results carry no unknown bits
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, out_valid})
        && (!out_valid || !$isunknown({quat_w, quat_x, quat_y, quat_z})))
        else $error("unknown value on handshake or result");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int FB = rmq_pkg::FRAC_BITS_DEF;
    localparam int ONE = 1 << FB;
    localparam int LATENCY = 60;
    localparam int N_RANDOM = 1750;

    typedef logic signed [rmq_pkg::DATA_W-1:0] fx_t;

    typedef struct {
        fx_t m [9];
    } matrix_t;

    typedef struct {
        fx_t w;
        fx_t x;
        fx_t y;
        fx_t z;
    } quat_t;

    // directed row: matrix, flag for a typed-in expectation, and that expectation
    typedef struct {
        matrix_t mat;
        bit      fixed;
        quat_t   q;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    fx_t  r11 = '0, r12 = '0, r13 = '0, r21 = '0, r22 = '0, r23 = '0;
    fx_t  r31 = '0, r32 = '0, r33 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fx_t  quat_w, quat_x, quat_y, quat_z;

    quat_t expected_quats [$];
    int    n_errors = 0;
    int    n_results = 0;
    int    n_requests = 0;
    bit    hold_long = 1'b0;
    bit    stim_done = 1'b0;

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .r11(r11), .r12(r12), .r13(r13), .r21(r21), .r22(r22), .r23(r23),
        .r31(r31), .r32(r32), .r33(r33),
        .out_valid(out_valid), .out_stall(out_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    // integer square root, rounded down
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // matrix to normalized quaternion
    function automatic quat_t matrix_to_quat(matrix_t mt);
        longint e [9];
        longint s [4];
        longint unsigned a [4];
        longint sg [4];
        longint unsigned sumsq;
        longint unsigned len;
        longint unsigned mag;
        longint v [4];
        int big;
        quat_t q;
        for (int i = 0; i < 9; i++)
            e[i] = longint'(mt.m[i]);
        s[0] = e[0] + e[4] + e[8] + ONE;
        s[1] = e[0] - e[4] - e[8] + ONE;
        s[2] = -e[0] + e[4] - e[8] + ONE;
        s[3] = -e[0] - e[4] + e[8] + ONE;
        sumsq = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (s[i] < 0)
                s[i] = 0;
            a[i] = int_sqrt(longint'(s[i]) << FB);
            sumsq += a[i] * a[i];
        end
        big = 0;
        for (int i = 1; i < 4; i++)
            if (s[i] > s[big])
                big = i;
        for (int i = 0; i < 4; i++)
            sg[i] = 1;
        case (big)
            0:
            begin
                sg[1] = (e[7] - e[5] >= 0) ? 1 : -1;
                sg[2] = (e[2] - e[6] >= 0) ? 1 : -1;
                sg[3] = (e[3] - e[1] >= 0) ? 1 : -1;
            end
            1:
            begin
                sg[0] = (e[7] - e[5] >= 0) ? 1 : -1;
                sg[2] = (e[3] + e[1] >= 0) ? 1 : -1;
                sg[3] = (e[2] + e[6] >= 0) ? 1 : -1;
            end
            2:
            begin
                sg[0] = (e[2] - e[6] >= 0) ? 1 : -1;
                sg[1] = (e[3] + e[1] >= 0) ? 1 : -1;
                sg[3] = (e[7] + e[5] >= 0) ? 1 : -1;
            end
            default:
            begin
                sg[0] = (e[3] - e[1] >= 0) ? 1 : -1;
                sg[1] = (e[6] + e[2] >= 0) ? 1 : -1;
                sg[2] = (e[7] + e[5] >= 0) ? 1 : -1;
            end
        endcase
        len = int_sqrt(sumsq);
        for (int i = 0; i < 4; i++)
        begin
            if (len == 0)
                v[i] = (i == 0) ? longint'(ONE) : longint'(0);
            else
            begin
                mag = ((a[i] << FB) + (len >> 1)) / len;
                if (mag > ONE)
                    mag = ONE;
                v[i] = longint'(mag) * sg[i];
            end
        end
        q.w = v[0][rmq_pkg::DATA_W-1:0];
        q.x = v[1][rmq_pkg::DATA_W-1:0];
        q.y = v[2][rmq_pkg::DATA_W-1:0];
        q.z = v[3][rmq_pkg::DATA_W-1:0];
        return q;
    endfunction

    task automatic report_mismatch(string what, fx_t got, fx_t want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, n_results, got, want);
        n_errors++;
    endtask

    function automatic matrix_t make_mat(int a0, int a1, int a2, int a3, int a4,
                                         int a5, int a6, int a7, int a8);
        matrix_t mt;
        mt.m[0] = fx_t'(a0); mt.m[1] = fx_t'(a1); mt.m[2] = fx_t'(a2);
        mt.m[3] = fx_t'(a3); mt.m[4] = fx_t'(a4); mt.m[5] = fx_t'(a5);
        mt.m[6] = fx_t'(a6); mt.m[7] = fx_t'(a7); mt.m[8] = fx_t'(a8);
        return mt;
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = fx_t'(w);
        q.x = fx_t'(x);
        q.y = fx_t'(y);
        q.z = fx_t'(z);
        return q;
    endfunction

    function automatic dir_row_t make_row(matrix_t mt, bit fixed, quat_t q);
        dir_row_t r;
        r.mat = mt;
        r.fixed = fixed;
        r.q = q;
        return r;
    endfunction

    // random rotation-like matrix from a random quaternion, or noise
    function automatic matrix_t random_matrix();
        matrix_t mt;
        real qw, qx, qy, qz, nq;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            qw = $urandom_range(0, 2000) - 1000.0;
            qx = $urandom_range(0, 2000) - 1000.0;
            qy = $urandom_range(0, 2000) - 1000.0;
            qz = $urandom_range(0, 2000) - 1000.0;
            nq = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz);
            if (nq < 1.0)
            begin
                qw = 1.0;
                nq = 1.0;
            end
            qw /= nq; qx /= nq; qy /= nq; qz /= nq;
            mt.m[0] = fx_t'($rtoi(ONE * (1.0 - 2.0*(qy*qy + qz*qz))));
            mt.m[1] = fx_t'($rtoi(ONE * 2.0*(qx*qy - qz*qw)));
            mt.m[2] = fx_t'($rtoi(ONE * 2.0*(qx*qz + qy*qw)));
            mt.m[3] = fx_t'($rtoi(ONE * 2.0*(qx*qy + qz*qw)));
            mt.m[4] = fx_t'($rtoi(ONE * (1.0 - 2.0*(qx*qx + qz*qz))));
            mt.m[5] = fx_t'($rtoi(ONE * 2.0*(qy*qz - qx*qw)));
            mt.m[6] = fx_t'($rtoi(ONE * 2.0*(qx*qz - qy*qw)));
            mt.m[7] = fx_t'($rtoi(ONE * 2.0*(qy*qz + qx*qw)));
            mt.m[8] = fx_t'($rtoi(ONE * (1.0 - 2.0*(qx*qx + qy*qy))));
        end
        else if (sel < 9)
        begin
            for (int i = 0; i < 9; i++)
                mt.m[i] = fx_t'(int'($urandom_range(0, 2*ONE)) - ONE);
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                mt.m[i] = fx_t'($urandom());
        end
        return mt;
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(matrix_t mt, bit fixed, quat_t q);
        r11 <= mt.m[0]; r12 <= mt.m[1]; r13 <= mt.m[2];
        r21 <= mt.m[3]; r22 <= mt.m[4]; r23 <= mt.m[5];
        r31 <= mt.m[6]; r32 <= mt.m[7]; r33 <= mt.m[8];
        in_valid <= 1'b1;
        expected_quats.insert(expected_quats.size(), fixed ? q : matrix_to_quat(mt));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_requests++;
        @(negedge clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        quat_t qid;
        quat_t qhx;
        quat_t qhy;
        quat_t qhz;
        quat_t qnone;
        int gap_mode;
        qid = make_quat(ONE, 0, 0, 0);
        qhx = make_quat(0, ONE, 0, 0);
        qhy = make_quat(0, 0, ONE, 0);
        qhz = make_quat(0, 0, 0, ONE);
        qnone = make_quat(0, 0, 0, 0);
        // identity and half-turns about each axis
        rows.insert(rows.size(), make_row(make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
                                          1'b1, qid));
        rows.insert(rows.size(), make_row(make_mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE),
                                          1'b1, qhx));
        rows.insert(rows.size(), make_row(make_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE),
                                          1'b1, qhy));
        rows.insert(rows.size(), make_row(make_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE),
                                          1'b1, qhz));
        // quarter turns, both directions, each axis
        rows.insert(rows.size(), make_row(make_mat(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, 0, -ONE, 0, ONE, 0, ONE, 0, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE),
                                          1'b0, qnone));
        // ties between candidates, zero differences count as positive
        rows.insert(rows.size(), make_row(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, ONE, 0, ONE, 0, 0, 0, 0, -ONE),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE),
                                          1'b0, qnone));
        // half-turns with negative off-diagonal sums
        rows.insert(rows.size(), make_row(make_mat(0, -ONE, 0, -ONE, 0, 0, 0, 0, -ONE),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(0, 0, -ONE, 0, -ONE, 0, -ONE, 0, 0),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-ONE, 0, 0, 0, 0, -ONE, 0, -ONE, 0),
                                          1'b0, qnone));
        // all-extreme entries and raw 16-bit extremes
        rows.insert(rows.size(), make_row(make_mat(ONE, ONE, ONE, ONE, ONE, ONE, ONE,
                                                   ONE, ONE), 1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE,
                                                   -ONE, -ONE, -ONE), 1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(32767, -32768, 32767, -32768, 32767,
                                                   -32768, 32767, -32768, 32767),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-32768, 32767, -32768, 32767, -32768,
                                                   32767, -32768, 32767, -32768),
                                          1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-32768, -32768, -32768, -32768,
                                                   -32768, -32768, -32768, -32768,
                                                   -32768), 1'b0, qnone));
        rows.insert(rows.size(), make_row(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1),
                                          1'b0, qnone));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, back to back
        foreach (rows[i])
        begin
            row = rows[i];
            send_request(row.mat, row.fixed, row.q);
        end

        // random part
        for (int k = 0; k < N_RANDOM; k++)
        begin
            // long receiver hold-off while requests keep coming
            if (k == 400)
                hold_long = 1'b1;
            // pause until the pipeline has drained
            if (k == 900)
            begin
                in_valid <= 1'b0;
                while (expected_quats.size() != 0)
                    @(negedge clk);
            end
            send_request(random_matrix(), 1'b0, qnone);
            gap_mode = (k / 200) % 3;
            if (gap_mode == 1)
                idle_gap($urandom_range(0, 10));
            else if (gap_mode == 2 && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(0, 10));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern
    initial
    begin
        int wait_cycles;
        int phase;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                phase++;
                wait_cycles = ((phase / 300) % 2 == 0) ? $urandom_range(0, 10) : 0;
                if (wait_cycles > 0 && $urandom_range(0, 2) == 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_quats.size() == 0)
            begin
                $display("unexpected result: w %0d x %0d y %0d z %0d",
                         quat_w, quat_x, quat_y, quat_z);
                n_errors++;
            end
            else
            begin
                want = expected_quats.pop_front();
                if (quat_w !== want.w)
                    report_mismatch("quat_w", quat_w, want.w);
                if (quat_x !== want.x)
                    report_mismatch("quat_x", quat_x, want.x);
                if (quat_y !== want.y)
                    report_mismatch("quat_y", quat_y, want.y);
                if (quat_z !== want.z)
                    report_mismatch("quat_z", quat_z, want.z);
            end
            n_results++;
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (expected_quats.size() != 0)
            @(negedge clk);
        repeat (LATENCY * 2) @(negedge clk);
        $display("%0d matrices sent, %0d quaternions checked (directed axes, ties,",
                 n_requests, n_results);
        $display("extremes, random rotations and noise, with stalls on both sides)");
        if (n_errors == 0 && expected_quats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_quats.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
